// ----- hdl/sse_pkg.sv -----
// ----------------------------------------------------------------------------
// sse_pkg
// shared types, codes and sizes for the synapse segment engine
// ----------------------------------------------------------------------------
package sse_pkg;

   localparam int MAX_SYNAPSES = 32;
   localparam int IDX_W        = $clog2(MAX_SYNAPSES);
   localparam int CNT_W        = 6;
   localparam int CELL_W       = 16;
   localparam int PERM_W       = 16;
   localparam int KIND_W       = 3;
   localparam int STAT_W       = 3;
   localparam int ATHR_W       = 6;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SYNAPSES);

   // operation kinds
   localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MARK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EVAL  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DECAY = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FREE  = 3'd4;

   // result status codes
   localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STAT_W-1:0] ST_DUP     = 3'd2;
   localparam logic [STAT_W-1:0] ST_REMOVED = 3'd3;
   localparam logic [STAT_W-1:0] ST_MARKED  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CONNECT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERM_MAX = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CELL_W-1:0] src_cell;
      logic [PERM_W-1:0] permanence;
      logic [CNT_W-1:0]  free_count;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [CELL_W-1:0] removed_cell;
      logic [CNT_W-1:0]  active_count;
      logic [CNT_W-1:0]  connected_active_count;
      logic              segment_active;
      logic [CNT_W-1:0]  connected_total;
      logic [CNT_W-1:0]  entry_count;
      logic              last;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_ADD_SCAN, S_ADD_DECIDE, S_SHIFT, S_PUT, S_MARK, S_EVAL, S_EVAL_FIN,
      S_DECAY, S_FIN, S_FREE_CNT, S_FREE_SETUP, S_SRCH_INIT, S_SRCH, S_PICK,
      S_COMPACT, S_EMIT_RD, S_EMIT_LD
   } state_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_LOAD, DP_ADD_SCAN, DP_ADD_DECIDE, DP_SHIFT, DP_PUT, DP_MARK,
      DP_EVAL, DP_EVAL_FIN, DP_DECAY, DP_FIN, DP_FREE_CNT, DP_FREE_SETUP,
      DP_SRCH_INIT, DP_SRCH, DP_PICK, DP_COMPACT, DP_EMIT_RD, DP_EMIT_LD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic add_stop;
      logic add_ok;
      logic shift_done;
      logic sweep_done;
      logic free_more;
      logic rsp_free;
      logic is_last;
   } dp_status_type;

endpackage

// ----- hdl/synapse_segment_engine.sv -----
// ----------------------------------------------------------------------------
// synapse_segment_engine
// one segment's ordered synapse table with add, mark, evaluate, decay, free
// ----------------------------------------------------------------------------
//  channel | ports                          | direction | beat
//  req     | req_valid req_stall req_data   | in        | one operation
//  rsp     | rsp_valid rsp_stall rsp_data   | out       | one result
//  csr     | csr_we csr_index csr_wdata     | in        | one register write
//
//  one operation at a time; the table is swept one entry a cycle
//  add scans to the insertion point, then shifts the tail up and puts the new entry
//  mark, evaluate and decay sweep the table once; free counts unmarked entries first
//  free then repeats the search sweep once per freed synapse and compacts the table
//  each result beat is read from the removal queue, then loaded as the result
//  reset empties the table and restores register defaults
//  the last result may wait under rsp_stall while the next req beat is taken
// ----------------------------------------------------------------------------
module synapse_segment_engine (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sse_pkg::req_type                  req_data,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sse_pkg::rsp_type                  rsp_data,
   // register writes
   input  logic                              csr_we,
   input  logic [sse_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sse_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sse_pkg::*;

   cmd_type       cmd;
   dp_status_type status;

   // sequencer: walks each operation through its sweeps
   sse_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // table, counters and result register
   sse_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hdl/sse_datapath.sv -----
// ----------------------------------------------------------------------------
// sse_datapath
// synapse table, counters, removal queue and result register
// ----------------------------------------------------------------------------
module sse_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  sse_pkg::req_type                  req_data,
   input  logic                              csr_we,
   input  logic [sse_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sse_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  sse_pkg::cmd_type                  cmd,
   output sse_pkg::dp_status_type            status,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sse_pkg::rsp_type                  rsp_data
);
   import sse_pkg::*;

   logic [CELL_W-1:0] cell_mem [MAX_SYNAPSES];
   logic [PERM_W-1:0] perm_mem [MAX_SYNAPSES];
   logic [CELL_W-1:0] q_mem    [MAX_SYNAPSES];
   logic [MAX_SYNAPSES-1:0] mark_ff, gone_ff;

   logic [PERM_W-1:0] thr_ff, decay_ff, pmax_ff;
   logic [ATHR_W-1:0] athr_ff;

   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  idx_ff, idx_in, wr_ff, wr_in, pos_ff, pos_in, k_ff, k_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, idle_ff, idle_in, act_ff, act_in;
   logic [CNT_W-1:0]  cact_ff, cact_in, qn_ff, qn_in, e_ff, e_in;
   logic [CNT_W-1:0]  total_ff, total_in, conn_ff, conn_in;
   logic              seg_ff, seg_in, use_m_ff, use_m_in, found_ff, found_in;
   logic [STAT_W-1:0] stat_ff, stat_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   logic [PERM_W:0]   bkey_ff, bkey_in;
   logic [PERM_W-1:0] bperm_ff, bperm_in;
   logic [CELL_W-1:0] bcell_ff, bcell_in, qrd_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [CNT_W-1:0]  wr_m1;
   logic [IDX_W-1:0]  rd_addr;
   logic [CELL_W-1:0] cell_rd;
   logic [PERM_W-1:0] perm_rd, perm_dec;
   logic              mark_rd, gone_rd, in_range, rsp_free;
   logic [PERM_W:0]   key;
   logic              eligible;

   logic              mem_we, mark_wd;
   logic [IDX_W-1:0]  mem_wa;
   logic [CELL_W-1:0] cell_wd;
   logic [PERM_W-1:0] perm_wd;
   logic              q_we;
   logic [CELL_W-1:0] q_wd;
   logic [CNT_W-1:0]  want_sat;

   assign wr_m1    = wr_ff - CNT_W'(1);
   assign rd_addr  = (cmd.op == DP_SHIFT) ? wr_m1[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign cell_rd  = cell_mem[rd_addr];
   assign perm_rd  = perm_mem[rd_addr];
   assign mark_rd  = mark_ff[rd_addr];
   assign gone_rd  = gone_ff[rd_addr];
   assign in_range = idx_ff < total_ff;
   assign perm_dec = perm_rd - decay_ff;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign key      = {1'b0, perm_rd} + (mark_rd ? {1'b0, pmax_ff} : {(PERM_W+1){1'b0}});
   assign eligible = in_range && !gone_rd && (!mark_rd || use_m_ff);
   assign want_sat = (req_ff.free_count > total_ff) ? total_ff : req_ff.free_count;

   // status to controller
   always_comb begin
      status.add_stop   = !(in_range && (cell_rd < req_ff.src_cell));
      status.add_ok     = !(in_range && (cell_rd == req_ff.src_cell)) && (total_ff < MAX_CNT);
      status.shift_done = (wr_ff <= pos_ff);
      status.sweep_done = !in_range;
      status.free_more  = (k_ff < cnt_ff);
      status.rsp_free   = rsp_free;
      status.is_last    = (e_ff == qn_ff);
   end

   // table write port
   always_comb begin
      mem_we  = 1'b0;
      mem_wa  = wr_ff[IDX_W-1:0];
      cell_wd = cell_rd;
      perm_wd = perm_rd;
      mark_wd = mark_rd;
      q_we    = 1'b0;
      q_wd    = cell_rd;
      unique case (cmd.op)
         DP_SHIFT: begin
            mem_we = (wr_ff > pos_ff);
         end
         DP_PUT: begin
            mem_we  = 1'b1;
            mem_wa  = pos_ff[IDX_W-1:0];
            cell_wd = req_ff.src_cell;
            perm_wd = req_ff.permanence;
            mark_wd = 1'b0;
         end
         DP_DECAY: begin
            mem_we  = in_range && (perm_rd > decay_ff);
            perm_wd = perm_dec;
            q_we    = in_range && (perm_rd <= decay_ff);
         end
         DP_COMPACT: begin
            mem_we = in_range && !gone_rd;
         end
         DP_PICK: begin
            q_we = found_ff;
            q_wd = bcell_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_wa] <= cell_wd;
         perm_mem[mem_wa] <= perm_wd;
      end
      if (q_we) begin
         q_mem[qn_ff[IDX_W-1:0]] <= q_wd;
      end
      if (cmd.op == DP_EMIT_RD) begin
         qrd_ff <= q_mem[e_ff[IDX_W-1:0]];
      end
   end

   // marks and removal flags
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= '0;
         gone_ff <= '0;
      end else begin
         if (cmd.op == DP_EVAL_FIN) begin
            mark_ff <= '0;
         end else if (cmd.op == DP_MARK) begin
            if (in_range && (cell_rd == req_ff.src_cell)) begin
               mark_ff[idx_ff[IDX_W-1:0]] <= 1'b1;
            end
         end else if (mem_we) begin
            mark_ff[mem_wa] <= mark_wd;
         end
         if (cmd.op == DP_LOAD) begin
            gone_ff <= '0;
         end else if ((cmd.op == DP_PICK) && found_ff) begin
            gone_ff[best_ff] <= 1'b1;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= 16'd16384;
         athr_ff  <= 6'd8;
         decay_ff <= 16'd33;
         pmax_ff  <= 16'd32768;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CONNECT:  thr_ff   <= csr_wdata;
            CSR_ACTIVATE: athr_ff  <= csr_wdata[ATHR_W-1:0];
            CSR_DECAY:    decay_ff <= csr_wdata;
            CSR_PERM_MAX: pmax_ff  <= csr_wdata;
         endcase
      end
   end

   // counters and result
   always_comb begin
      req_in       = req_ff;
      idx_in       = idx_ff;
      wr_in        = wr_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      idle_in      = idle_ff;
      act_in       = act_ff;
      cact_in      = cact_ff;
      qn_in        = qn_ff;
      e_in         = e_ff;
      total_in     = total_ff;
      conn_in      = conn_ff;
      seg_in       = seg_ff;
      use_m_in     = use_m_ff;
      found_in     = found_ff;
      stat_in      = stat_ff;
      best_in      = best_ff;
      bkey_in      = bkey_ff;
      bperm_in     = bperm_ff;
      bcell_in     = bcell_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (cmd.op)
         DP_LOAD: begin
            req_in  = req_data;
            idx_in  = '0;
            wr_in   = '0;
            k_in    = '0;
            idle_in = '0;
            act_in  = '0;
            cact_in = '0;
            qn_in   = '0;
            e_in    = '0;
            seg_in  = 1'b0;
            found_in = 1'b0;
            stat_in = ST_DONE;
         end
         DP_ADD_SCAN: begin
            if (in_range && (cell_rd < req_ff.src_cell)) idx_in = idx_ff + CNT_W'(1);
         end
         DP_ADD_DECIDE: begin
            pos_in = idx_ff;
            wr_in  = total_ff;
            if (in_range && (cell_rd == req_ff.src_cell)) stat_in = ST_DUP;
            else if (total_ff >= MAX_CNT)                stat_in = ST_FULL;
         end
         DP_SHIFT: begin
            if (wr_ff > pos_ff) wr_in = wr_m1;
         end
         DP_PUT: begin
            total_in = total_ff + CNT_W'(1);
            if ((req_ff.permanence >= thr_ff) && (conn_ff < MAX_CNT))
               conn_in = conn_ff + CNT_W'(1);
         end
         DP_MARK: begin
            if (in_range && (cell_rd == req_ff.src_cell)) stat_in = ST_MARKED;
            idx_in = idx_ff + CNT_W'(1);
         end
         DP_EVAL: begin
            if (in_range && mark_rd) begin
               act_in = act_ff + CNT_W'(1);
               if (perm_rd >= thr_ff) cact_in = cact_ff + CNT_W'(1);
            end
            idx_in = idx_ff + CNT_W'(1);
         end
         DP_EVAL_FIN: begin
            seg_in = (cact_ff >= athr_ff);
         end
         DP_DECAY: begin
            if (in_range) begin
               if (perm_rd <= decay_ff) begin
                  if ((perm_rd >= thr_ff) && (conn_ff != '0)) conn_in = conn_ff - CNT_W'(1);
                  qn_in = qn_ff + CNT_W'(1);
               end else begin
                  wr_in = wr_ff + CNT_W'(1);
                  if ((perm_rd >= thr_ff) && (perm_dec < thr_ff) && (conn_ff != '0))
                     conn_in = conn_ff - CNT_W'(1);
               end
            end
            idx_in = idx_ff + CNT_W'(1);
         end
         DP_FIN: begin
            total_in = wr_ff;
         end
         DP_FREE_CNT: begin
            if (in_range && !mark_rd) idle_in = idle_ff + CNT_W'(1);
            idx_in = idx_ff + CNT_W'(1);
         end
         DP_FREE_SETUP: begin
            cnt_in   = want_sat;
            use_m_in = (idle_ff < want_sat);
         end
         DP_SRCH_INIT: begin
            idx_in   = '0;
            wr_in    = '0;
            found_in = 1'b0;
         end
         DP_SRCH: begin
            if (eligible && (!found_ff || (key < bkey_ff))) begin
               found_in = 1'b1;
               best_in  = idx_ff[IDX_W-1:0];
               bkey_in  = key;
               bperm_in = perm_rd;
               bcell_in = cell_rd;
            end
            idx_in = idx_ff + CNT_W'(1);
         end
         DP_PICK: begin
            if (found_ff) begin
               if ((bperm_ff >= thr_ff) && (conn_ff != '0)) conn_in = conn_ff - CNT_W'(1);
               qn_in = qn_ff + CNT_W'(1);
               k_in  = k_ff + CNT_W'(1);
            end else begin
               k_in = cnt_ff;
            end
         end
         DP_COMPACT: begin
            if (in_range && !gone_rd) wr_in = wr_ff + CNT_W'(1);
            idx_in = idx_ff + CNT_W'(1);
         end
         DP_EMIT_LD: begin
            if (rsp_free) begin
               rsp_valid_in                  = 1'b1;
               rsp_in.status                 = (e_ff < qn_ff) ? ST_REMOVED : stat_ff;
               rsp_in.removed_cell           = (e_ff < qn_ff) ? qrd_ff : '0;
               rsp_in.active_count           = act_ff;
               rsp_in.connected_active_count = cact_ff;
               rsp_in.segment_active         = seg_ff;
               rsp_in.connected_total        = conn_ff;
               rsp_in.entry_count            = total_ff;
               rsp_in.last                   = (e_ff == qn_ff);
               e_in                          = e_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         wr_ff        <= '0;
         pos_ff       <= '0;
         k_ff         <= '0;
         cnt_ff       <= '0;
         idle_ff      <= '0;
         act_ff       <= '0;
         cact_ff      <= '0;
         qn_ff        <= '0;
         e_ff         <= '0;
         total_ff     <= '0;
         conn_ff      <= '0;
         seg_ff       <= 1'b0;
         use_m_ff     <= 1'b0;
         found_ff     <= 1'b0;
         stat_ff      <= ST_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         wr_ff        <= wr_in;
         pos_ff       <= pos_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         idle_ff      <= idle_in;
         act_ff       <= act_in;
         cact_ff      <= cact_in;
         qn_ff        <= qn_in;
         e_ff         <= e_in;
         total_ff     <= total_in;
         conn_ff      <= conn_in;
         seg_ff       <= seg_in;
         use_m_ff     <= use_m_in;
         found_ff     <= found_in;
         stat_ff      <= stat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      best_ff  <= best_in;
      bkey_ff  <= bkey_in;
      bperm_ff <= bperm_in;
      bcell_ff <= bcell_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/sse_controller.sv -----
// ----------------------------------------------------------------------------
// sse_controller
// sequencer for the segment operations
// ----------------------------------------------------------------------------
module sse_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [sse_pkg::KIND_W-1:0]    req_kind,
   output logic                          req_stall,
   input  sse_pkg::dp_status_type        status,
   output sse_pkg::cmd_type              cmd
);
   import sse_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = DP_NOP;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = DP_LOAD;
               unique case (req_kind)
                  KIND_ADD:   state_in = S_ADD_SCAN;
                  KIND_MARK:  state_in = S_MARK;
                  KIND_EVAL:  state_in = S_EVAL;
                  KIND_DECAY: state_in = S_DECAY;
                  KIND_FREE:  state_in = S_FREE_CNT;
                  default:    state_in = S_EMIT_RD;
               endcase
            end
         end
         S_ADD_SCAN: begin
            cmd.op = DP_ADD_SCAN;
            if (status.add_stop) state_in = S_ADD_DECIDE;
         end
         S_ADD_DECIDE: begin
            cmd.op   = DP_ADD_DECIDE;
            state_in = status.add_ok ? S_SHIFT : S_EMIT_RD;
         end
         S_SHIFT: begin
            cmd.op = DP_SHIFT;
            if (status.shift_done) state_in = S_PUT;
         end
         S_PUT: begin
            cmd.op   = DP_PUT;
            state_in = S_EMIT_RD;
         end
         S_MARK: begin
            if (status.sweep_done) state_in = S_EMIT_RD;
            else                   cmd.op   = DP_MARK;
         end
         S_EVAL: begin
            if (status.sweep_done) state_in = S_EVAL_FIN;
            else                   cmd.op   = DP_EVAL;
         end
         S_EVAL_FIN: begin
            cmd.op   = DP_EVAL_FIN;
            state_in = S_EMIT_RD;
         end
         S_DECAY: begin
            if (status.sweep_done) state_in = S_FIN;
            else                   cmd.op   = DP_DECAY;
         end
         S_FIN: begin
            cmd.op   = DP_FIN;
            state_in = S_EMIT_RD;
         end
         S_FREE_CNT: begin
            if (status.sweep_done) state_in = S_FREE_SETUP;
            else                   cmd.op   = DP_FREE_CNT;
         end
         S_FREE_SETUP: begin
            cmd.op   = DP_FREE_SETUP;
            state_in = S_SRCH_INIT;
         end
         S_SRCH_INIT: begin
            cmd.op   = DP_SRCH_INIT;
            state_in = status.free_more ? S_SRCH : S_COMPACT;
         end
         S_SRCH: begin
            if (status.sweep_done) state_in = S_PICK;
            else                   cmd.op   = DP_SRCH;
         end
         S_PICK: begin
            cmd.op   = DP_PICK;
            state_in = S_SRCH_INIT;
         end
         S_COMPACT: begin
            if (status.sweep_done) state_in = S_FIN;
            else                   cmd.op   = DP_COMPACT;
         end
         S_EMIT_RD: begin
            cmd.op   = DP_EMIT_RD;
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            cmd.op = DP_EMIT_LD;
            if (status.rsp_free) state_in = status.is_last ? S_IDLE : S_EMIT_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/sse_checker.sv -----
// ----------------------------------------------------------------------------
// sse_checker
// port level checks for the synapse segment engine
// ----------------------------------------------------------------------------
module sse_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  sse_pkg::rsp_type  rsp_data
);
   import sse_pkg::*;

   // a stalled result stays
   a_hold_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped under stall");

   a_hold_data : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result changed under stall");

   // removals are always followed by a closing beat
   a_removed_not_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_REMOVED) |-> !rsp_data.last)
      else $error("removal flagged last");

   // single result codes close their operation
   a_single_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.status == ST_FULL) || (rsp_data.status == ST_DUP) ||
                    (rsp_data.status == ST_MARKED)) |-> rsp_data.last)
      else $error("single result not last");

   a_counts : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entry_count <= MAX_CNT) &&
                    (rsp_data.connected_total <= MAX_CNT))
      else $error("count beyond table size");

endmodule

bind synapse_segment_engine sse_checker u_sse_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
